### src/spq_pkg.sv
`default_nettype none

package spq_pkg;

  localparam int CAPACITY_DEF  = 256;
  localparam int DAY_BITS_DEF  = 9;
  localparam int NODE_BITS_DEF = 14;

  typedef enum logic [0:0] {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_t;

  // Per-cycle command broadcast to every cell of the row
  typedef struct packed {
    logic ins;
    logic del;
  } cell_ctrl_t;

endpackage

`default_nettype wire

### src/spq_cell.sv
`default_nettype none

module spq_cell #(
  parameter int IDX       = 0,
  parameter int NODE_BITS = spq_pkg::NODE_BITS_DEF,
  parameter int DAY_BITS  = spq_pkg::DAY_BITS_DEF,
  parameter int CNT_W     = 9
) (
  input  wire logic                  clk,
  input  wire spq_pkg::cell_ctrl_t   ctrl,
  input  wire logic [CNT_W-1:0]      count,
  input  wire logic [NODE_BITS-1:0]  new_node,
  input  wire logic [DAY_BITS-1:0]   new_day,
  input  wire logic                  new_kind,
  input  wire logic [NODE_BITS-1:0]  left_node,
  input  wire logic [DAY_BITS-1:0]   left_day,
  input  wire logic                  left_kind,
  input  wire logic                  left_atp,
  input  wire logic [NODE_BITS-1:0]  right_node,
  input  wire logic [DAY_BITS-1:0]   right_day,
  input  wire logic                  right_kind,
  output logic                       atp,
  output logic [NODE_BITS-1:0]       node_nxt,
  output logic [DAY_BITS-1:0]        day_nxt,
  output logic                       kind_nxt,
  output logic [NODE_BITS-1:0]       node_r,
  output logic [DAY_BITS-1:0]        day_r,
  output logic                       kind_r
);

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

  logic occupied;

  assign occupied = (count > MY_IDX);

  // atp: this slot sits at or after the insertion point
  generate
    if (IDX == 0) begin : g_head
      assign atp = !occupied || (day_r > new_day);
    end else begin : g_body
      assign atp = !occupied || (day_r >= new_day);
    end
  endgenerate

  always_comb begin
    node_nxt = node_r;
    day_nxt  = day_r;
    kind_nxt = kind_r;
    if (ctrl.del) begin
      node_nxt = right_node;
      day_nxt  = right_day;
      kind_nxt = right_kind;
    end else if (ctrl.ins && atp) begin
      if (!left_atp) begin
        node_nxt = new_node;
        day_nxt  = new_day;
        kind_nxt = new_kind;
      end else begin
        node_nxt = left_node;
        day_nxt  = left_day;
        kind_nxt = left_kind;
      end
    end
  end

  always_ff @(posedge clk) begin
    node_r <= node_nxt;
    day_r  <= day_nxt;
    kind_r <= kind_nxt;
  end

endmodule

`default_nettype wire

### src/sorted_event_priority_queue.sv
`default_nettype none

// Day-ordered event queue built as a row of CAPACITY slot cells. Every cell
// compares its own day with the incoming word and looks only at its left
// neighbor to decide whether to keep its entry, take the new event or shift
// right; a dequeue shifts the whole row left. One operation is accepted per
// clock and its result word is captured in the output register;
// the only back-pressure is a full output register that is not being taken.
// A new event with the same day as the front goes behind it; further back, a
// new event goes ahead of entries with an equal day. A full queue drops an
// enqueue and raises overflow_flag; an empty queue flags a dequeue with
// underflow_flag. No clearing pass after reset.
module sorted_event_priority_queue #(
  parameter int CAPACITY  = spq_pkg::CAPACITY_DEF,
  parameter int DAY_BITS  = spq_pkg::DAY_BITS_DEF,
  parameter int NODE_BITS = spq_pkg::NODE_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              in_opcode,
  input  wire logic [NODE_BITS-1:0]              in_event_node,
  input  wire logic [DAY_BITS-1:0]               in_event_day,
  input  wire logic                              in_event_kind,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   out_head_valid,
  output logic [NODE_BITS-1:0]                   out_head_node,
  output logic [DAY_BITS-1:0]                    out_head_day,
  output logic                                   out_head_kind,
  output logic [$clog2(CAPACITY+1)-1:0]          out_occupancy,
  output logic                                   out_underflow_flag,
  output logic                                   out_overflow_flag
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

  spq_pkg::cell_ctrl_t ctrl;

  logic                 accept;
  logic                 is_deq;
  logic                 full;
  logic                 empty;
  logic [CNT_W-1:0]     count_r;
  logic [CNT_W-1:0]     count_nxt;
  logic                 out_valid_r;

  logic [NODE_BITS-1:0] c_node     [CAPACITY];
  logic [DAY_BITS-1:0]  c_day      [CAPACITY];
  logic                 c_kind     [CAPACITY];
  logic                 c_atp      [CAPACITY];
  logic [NODE_BITS-1:0] c_node_nxt [CAPACITY];
  logic [DAY_BITS-1:0]  c_day_nxt  [CAPACITY];
  logic                 c_kind_nxt [CAPACITY];

  logic                 head_valid_r;
  logic [NODE_BITS-1:0] head_node_r;
  logic [DAY_BITS-1:0]  head_day_r;
  logic                 head_kind_r;
  logic                 under_r;
  logic                 over_r;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign is_deq   = (in_opcode == spq_pkg::OP_DEQ);
  assign full     = (count_r == FULL_CNT);
  assign empty    = (count_r == '0);

  assign ctrl = '{ins: accept && !is_deq && !full, del: accept && is_deq && !empty};

  always_comb begin
    count_nxt = count_r;
    if (ctrl.ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctrl.del) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  generate
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [NODE_BITS-1:0] l_node;
      logic [DAY_BITS-1:0]  l_day;
      logic                 l_kind;
      logic                 l_atp;
      logic [NODE_BITS-1:0] r_node;
      logic [DAY_BITS-1:0]  r_day;
      logic                 r_kind;

      if (i == 0) begin : g_left_edge
        assign l_node = in_event_node;
        assign l_day  = in_event_day;
        assign l_kind = in_event_kind;
        assign l_atp  = 1'b0;
      end else begin : g_left
        assign l_node = c_node[i-1];
        assign l_day  = c_day[i-1];
        assign l_kind = c_kind[i-1];
        assign l_atp  = c_atp[i-1];
      end

      // last cell refills from itself; that slot is empty after a dequeue
      if (i == CAPACITY - 1) begin : g_right_edge
        assign r_node = c_node[i];
        assign r_day  = c_day[i];
        assign r_kind = c_kind[i];
      end else begin : g_right
        assign r_node = c_node[i+1];
        assign r_day  = c_day[i+1];
        assign r_kind = c_kind[i+1];
      end

      spq_cell #(
        .IDX       (i),
        .NODE_BITS (NODE_BITS),
        .DAY_BITS  (DAY_BITS),
        .CNT_W     (CNT_W)
      ) u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .count      (count_r),
        .new_node   (in_event_node),
        .new_day    (in_event_day),
        .new_kind   (in_event_kind),
        .left_node  (l_node),
        .left_day   (l_day),
        .left_kind  (l_kind),
        .left_atp   (l_atp),
        .right_node (r_node),
        .right_day  (r_day),
        .right_kind (r_kind),
        .atp        (c_atp[i]),
        .node_nxt   (c_node_nxt[i]),
        .day_nxt    (c_day_nxt[i]),
        .kind_nxt   (c_kind_nxt[i]),
        .node_r     (c_node[i]),
        .day_r      (c_day[i]),
        .kind_r     (c_kind[i])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result word built from the front cell's next value
  always_ff @(posedge clk) begin
    if (accept) begin
      head_valid_r <= (count_nxt != '0);
      head_node_r  <= (count_nxt != '0) ? c_node_nxt[0] : '0;
      head_day_r   <= (count_nxt != '0) ? c_day_nxt[0] : '0;
      head_kind_r  <= (count_nxt != '0) ? c_kind_nxt[0] : 1'b0;
      under_r      <= is_deq && empty;
      over_r       <= !is_deq && full;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_head_valid     = head_valid_r;
  assign out_head_node      = head_node_r;
  assign out_head_day       = head_day_r;
  assign out_head_kind      = head_kind_r;
  assign out_occupancy      = count_r;
  assign out_underflow_flag = under_r;
  assign out_overflow_flag  = over_r;

endmodule

`default_nettype wire

### src/spq_checker.sv
`default_nettype none

module spq_checker #(
  parameter int CAPACITY  = spq_pkg::CAPACITY_DEF,
  parameter int DAY_BITS  = spq_pkg::DAY_BITS_DEF,
  parameter int NODE_BITS = spq_pkg::NODE_BITS_DEF
) (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic                              out_head_valid,
  input wire logic [NODE_BITS-1:0]              out_head_node,
  input wire logic [DAY_BITS-1:0]               out_head_day,
  input wire logic                              out_head_kind,
  input wire logic [$clog2(CAPACITY+1)-1:0]     out_occupancy,
  input wire logic                              out_underflow_flag,
  input wire logic                              out_overflow_flag
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_head_day)
      && $stable(out_occupancy) && $stable(out_head_node))
    else $error("result word changed while stalled");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_underflow_flag && out_overflow_flag))
    else $error("underflow and overflow in one word");

  a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_head_valid |-> out_occupancy == '0 && out_head_node == '0
      && out_head_day == '0 && !out_head_kind)
    else $error("empty queue shows a front event");

  a_head_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_head_valid |-> out_occupancy != '0 && !out_underflow_flag)
    else $error("front event with zero occupancy");

  a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow_flag |-> out_occupancy == FULL_CNT)
    else $error("overflow while queue not full");

endmodule

bind sorted_event_priority_queue spq_checker #(
  .CAPACITY  (CAPACITY),
  .DAY_BITS  (DAY_BITS),
  .NODE_BITS (NODE_BITS)
) u_spq_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_head_valid     (out_head_valid),
  .out_head_node      (out_head_node),
  .out_head_day       (out_head_day),
  .out_head_kind      (out_head_kind),
  .out_occupancy      (out_occupancy),
  .out_underflow_flag (out_underflow_flag),
  .out_overflow_flag  (out_overflow_flag)
);

`default_nettype wire
